// ----- rtl/strbr_pkg.sv -----
// Shared types and constants for the strobed parallel byte receiver.
`default_nettype none

package strbr_pkg;

    localparam int unsigned MessageLengthDefault = 16;
    localparam int unsigned TickW   = 24;
    localparam int unsigned CountW  = 32;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned PosOutW = 4;
    localparam int unsigned AddrW   = 3;
    localparam int unsigned DataW   = 32;

    localparam logic [TickW-1:0] HoldoffReset = 24'd25000;
    localparam logic [TickW-1:0] DelayReset   = 24'd40001;
    localparam logic [TickW-1:0] TickMax      = {TickW{1'b1}};

    // Request kinds.
    localparam logic KindTick  = 1'b0;
    localparam logic KindClear = 1'b1;

    // Register select, taken from paddr bit 2.
    localparam logic RegHoldoff = 1'b0;
    localparam logic RegDelay   = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             strobe_level;
        logic [ByteW-1:0] bus_byte;
    } t_in;

    typedef struct packed {
        logic               byte_valid;
        logic [ByteW-1:0]   byte_value;
        logic [PosOutW-1:0] byte_position;
        logic               message_end;
        logic               message_ready;
        logic [CountW-1:0]  blocks_received;
        logic [CountW-1:0]  edges_accepted;
        logic [CountW-1:0]  edges_rejected;
        logic [CountW-1:0]  bytes_sampled;
        logic               busy_res;
    } t_out;

endpackage

`default_nettype wire

// ----- rtl/strbr_core.sv -----
// Per-tick edge qualification, sampling delay, message position and counters.
`default_nettype none

module strbr_core #(
    parameter int unsigned MESSAGE_LENGTH = strbr_pkg::MessageLengthDefault
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire strbr_pkg::t_in               i_req,
    input  wire logic [strbr_pkg::TickW-1:0]  i_holdoff,
    input  wire logic [strbr_pkg::TickW-1:0]  i_delay,
    output strbr_pkg::t_out                   o_res
);

    localparam int unsigned PosW = (MESSAGE_LENGTH > 1) ? $clog2(MESSAGE_LENGTH) : 1;
    localparam logic [PosW-1:0] PosLast = PosW'(MESSAGE_LENGTH - 1);

    logic                          r_prev_strobe, n_prev_strobe;
    logic [strbr_pkg::TickW-1:0]   r_ticks, n_ticks;
    logic [strbr_pkg::TickW-1:0]   r_delay_count, n_delay_count;
    logic                          r_running, n_running;
    logic                          r_armed, n_armed;
    logic [PosW-1:0]               r_pos, n_pos;
    logic                          r_ready, n_ready;
    logic [strbr_pkg::CountW-1:0]  r_blocks, n_blocks;
    logic [strbr_pkg::CountW-1:0]  r_accepts, n_accepts;
    logic [strbr_pkg::CountW-1:0]  r_rejects, n_rejects;
    logic [strbr_pkg::CountW-1:0]  r_samples, n_samples;

    logic                          rising;
    logic [strbr_pkg::TickW-1:0]   ticks_inc;
    logic [strbr_pkg::TickW-1:0]   count_inc;
    logic                          smp_valid;
    logic                          smp_end;
    logic [PosW+strbr_pkg::PosOutW-1:0] pos_ext;

    assign rising    = i_req.strobe_level & ~r_prev_strobe;
    assign ticks_inc = (r_ticks != strbr_pkg::TickMax) ? r_ticks + 1'b1 : r_ticks;
    assign count_inc = r_delay_count + 1'b1;

    always_comb begin
        n_prev_strobe = r_prev_strobe;
        n_ticks       = r_ticks;
        n_delay_count = r_delay_count;
        n_running     = r_running;
        n_armed       = r_armed;
        n_pos         = r_pos;
        n_ready       = r_ready;
        n_blocks      = r_blocks;
        n_accepts     = r_accepts;
        n_rejects     = r_rejects;
        n_samples     = r_samples;
        smp_valid     = 1'b0;
        smp_end       = 1'b0;

        if (i_req.kind == strbr_pkg::KindClear) begin
            // Clear expires the holdoff but leaves a running delay alone.
            n_pos     = '0;
            n_ready   = 1'b0;
            n_blocks  = '0;
            n_accepts = '0;
            n_rejects = '0;
            n_samples = '0;
            n_armed   = 1'b0;
            n_ticks   = strbr_pkg::TickMax;
        end else begin
            n_prev_strobe = i_req.strobe_level;
            n_ticks       = ticks_inc;

            if (r_running) begin
                n_delay_count = count_inc;
                if (count_inc >= i_delay || count_inc == '0) begin
                    n_running = 1'b0;
                    if (r_armed) begin
                        n_armed   = 1'b0;
                        smp_valid = 1'b1;
                        n_samples = r_samples + 1'b1;
                        if (r_pos == PosLast) begin
                            n_pos    = '0;
                            n_ready  = 1'b1;
                            n_blocks = r_blocks + 1'b1;
                            smp_end  = 1'b1;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
            end

            // Edges are judged against the busy state from the start of the tick.
            if (rising && !r_running) begin
                if (ticks_inc < i_holdoff) begin
                    n_rejects = r_rejects + 1'b1;
                end else begin
                    n_accepts     = r_accepts + 1'b1;
                    n_ticks       = '0;
                    n_delay_count = '0;
                    n_running     = 1'b1;
                    n_armed       = 1'b1;
                end
            end
        end
    end

    assign pos_ext = {{strbr_pkg::PosOutW{1'b0}}, r_pos};

    always_comb begin
        o_res.byte_valid      = smp_valid;
        o_res.byte_value      = smp_valid ? i_req.bus_byte : '0;
        o_res.byte_position   = smp_valid ? pos_ext[strbr_pkg::PosOutW-1:0] : '0;
        o_res.message_end     = smp_end;
        o_res.message_ready   = n_ready;
        o_res.blocks_received = n_blocks;
        o_res.edges_accepted  = n_accepts;
        o_res.edges_rejected  = n_rejects;
        o_res.bytes_sampled   = n_samples;
        o_res.busy_res        = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_strobe <= 1'b0;
            r_ticks       <= '0;
            r_delay_count <= '0;
            r_running     <= 1'b0;
            r_armed       <= 1'b0;
            r_pos         <= '0;
            r_ready       <= 1'b0;
            r_blocks      <= '0;
            r_accepts     <= '0;
            r_rejects     <= '0;
            r_samples     <= '0;
        end else if (i_step) begin
            r_prev_strobe <= n_prev_strobe;
            r_ticks       <= n_ticks;
            r_delay_count <= n_delay_count;
            r_running     <= n_running;
            r_armed       <= n_armed;
            r_pos         <= n_pos;
            r_ready       <= n_ready;
            r_blocks      <= n_blocks;
            r_accepts     <= n_accepts;
            r_rejects     <= n_rejects;
            r_samples     <= n_samples;
        end
    end

    // A sample can only come out of a running, armed delay.
    a_sample_needs_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.byte_valid |-> r_running && r_armed)
        else $error("sample without an armed delay");

    // A message end is always carried by a sampled byte.
    a_end_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.message_end |-> o_res.byte_valid && o_res.message_ready)
        else $error("message end without a byte");

    // After a clear the counters read zero and the holdoff has expired.
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_req.kind == strbr_pkg::KindClear |=>
            r_accepts == '0 && r_rejects == '0 && r_samples == '0 &&
            r_blocks == '0 && !r_armed && r_ticks == strbr_pkg::TickMax)
        else $error("clear left state behind");

    // An armed sample never exists without a running delay.
    a_armed_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> r_running)
        else $error("armed sample outside a delay");

endmodule

`default_nettype wire

// ----- rtl/strobed_parallel_byte_receiver.sv -----
// Top level: register port, request handshake and result register of the byte receiver.
//
// Each request on the input channel is one time tick (kind 0, carrying the strobe
// level and the eight data lines) or a clear command (kind 1). Every request
// produces exactly one result on the output channel, with the sampled byte when
// a sampling delay ended on that tick, plus the running counters and flags.
// A request accepted at a clock edge shows its result at the output from the
// next cycle. Throughput is one request per cycle when unstalled; the whole
// tick update is one pass of logic from the state registers into the result
// register. The input is stalled only while a result is held and the receiver
// stalls, so a new request is taken whenever the result register empties at the
// same edge. A stalled result holds its value.
// The holdoff and sample delay registers sit at byte addresses 0 and 4 of the
// APB port and should be written only while the block is idle. Reset loads the
// registers with their defaults, clears all counters and flags, and treats the
// reset as an accepted edge, so edges in the first holdoff period are rejected.
`default_nettype none

module strobed_parallel_byte_receiver #(
    parameter int unsigned MESSAGE_LENGTH = strbr_pkg::MessageLengthDefault
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire strbr_pkg::t_in                i_in_data,

    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output strbr_pkg::t_out                    o_out_data,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [strbr_pkg::AddrW-1:0]   paddr,
    input  wire logic [strbr_pkg::DataW-1:0]   pwdata,
    output logic [strbr_pkg::DataW-1:0]        prdata,
    output logic                               pready
);

    logic [strbr_pkg::TickW-1:0] r_holdoff;
    logic [strbr_pkg::TickW-1:0] r_delay;
    logic                        r_out_valid;
    strbr_pkg::t_out             r_out_data;

    logic                        cfg_write;
    logic                        step;
    strbr_pkg::t_out             core_res;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff <= strbr_pkg::HoldoffReset;
            r_delay   <= strbr_pkg::DelayReset;
        end else if (cfg_write) begin
            case (paddr[2])
                strbr_pkg::RegHoldoff: r_holdoff <= pwdata[strbr_pkg::TickW-1:0];
                strbr_pkg::RegDelay:   r_delay   <= pwdata[strbr_pkg::TickW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            strbr_pkg::RegHoldoff: prdata = strbr_pkg::DataW'(r_holdoff);
            strbr_pkg::RegDelay:   prdata = strbr_pkg::DataW'(r_delay);
            default:               prdata = '0;
        endcase
    end

    assign o_in_stall = r_out_valid & i_out_stall;
    assign step       = i_in_valid & ~o_in_stall;

    strbr_core #(
        .MESSAGE_LENGTH(MESSAGE_LENGTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_req     (i_in_data),
        .i_holdoff (r_holdoff),
        .i_delay   (r_delay),
        .o_res     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- sim/strbr_report_checker.sv -----
// Checker for the strobed parallel byte receiver: predicts each report and compares it.
module strbr_report_checker #(
    parameter int unsigned MESSAGE_LENGTH = strbr_pkg::MessageLengthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  strbr_pkg::t_in                i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  strbr_pkg::t_out               i_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [strbr_pkg::AddrW-1:0]   paddr,
    input  logic [strbr_pkg::DataW-1:0]   pwdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow registers and receiver state.
    logic [strbr_pkg::TickW-1:0]  cfg_holdoff;
    logic [strbr_pkg::TickW-1:0]  cfg_delay;
    logic                         prev_strobe;
    logic [strbr_pkg::TickW-1:0]  elapsed;
    logic [strbr_pkg::TickW-1:0]  delay_ticks;
    logic                         delay_on;
    logic                         armed;
    int unsigned                  pos_idx;
    logic                         msg_ready;
    logic [strbr_pkg::CountW-1:0] n_blocks;
    logic [strbr_pkg::CountW-1:0] n_accepted;
    logic [strbr_pkg::CountW-1:0] n_rejected;
    logic [strbr_pkg::CountW-1:0] n_sampled;

    strbr_pkg::t_out predicted_reports[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_counts();
        pos_idx    = 0;
        msg_ready  = 1'b0;
        n_blocks   = '0;
        n_accepted = '0;
        n_rejected = '0;
        n_sampled  = '0;
        armed      = 1'b0;
    endfunction

    function automatic strbr_pkg::t_out predict_report(input strbr_pkg::t_in req);
        strbr_pkg::t_out rpt;
        logic rising;
        logic was_busy;
        rpt = '0;
        if (req.kind == strbr_pkg::KindClear) begin
            // Clear expires the holdoff but leaves the strobe history and delay alone.
            clear_counts();
            elapsed = strbr_pkg::TickMax;
        end else begin
            rising      = req.strobe_level && !prev_strobe;
            was_busy    = delay_on;
            prev_strobe = req.strobe_level;
            if (elapsed != strbr_pkg::TickMax) elapsed = elapsed + 1'b1;
            if (delay_on) begin
                delay_ticks = delay_ticks + 1'b1;
                // A delay setting of zero behaves like one.
                if (delay_ticks >= cfg_delay || delay_ticks == '0) begin
                    delay_on = 1'b0;
                    if (armed) begin
                        armed             = 1'b0;
                        rpt.byte_valid    = 1'b1;
                        rpt.byte_value    = req.bus_byte;
                        rpt.byte_position = pos_idx[strbr_pkg::PosOutW-1:0];
                        n_sampled         = n_sampled + 1'b1;
                        if (pos_idx + 1 >= MESSAGE_LENGTH) begin
                            pos_idx         = 0;
                            msg_ready       = 1'b1;
                            n_blocks        = n_blocks + 1'b1;
                            rpt.message_end = 1'b1;
                        end else begin
                            pos_idx = pos_idx + 1;
                        end
                    end
                end
            end
            // Edges are masked by the busy state from the start of the tick.
            if (rising && !was_busy) begin
                if (elapsed < cfg_holdoff) begin
                    n_rejected = n_rejected + 1'b1;
                end else begin
                    n_accepted  = n_accepted + 1'b1;
                    elapsed     = '0;
                    delay_ticks = '0;
                    delay_on    = 1'b1;
                    armed       = 1'b1;
                end
            end
        end
        rpt.message_ready   = msg_ready;
        rpt.blocks_received = n_blocks;
        rpt.edges_accepted  = n_accepted;
        rpt.edges_rejected  = n_rejected;
        rpt.bytes_sampled   = n_sampled;
        rpt.busy_res        = delay_on;
        return rpt;
    endfunction

    function automatic void check_field(input string fname,
                                        input logic [strbr_pkg::CountW-1:0] want,
                                        input logic [strbr_pkg::CountW-1:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", fname, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        strbr_pkg::t_out want;
        if (!i_rst_n) begin
            cfg_holdoff = strbr_pkg::HoldoffReset;
            cfg_delay   = strbr_pkg::DelayReset;
            prev_strobe = 1'b0;
            elapsed     = '0;
            delay_ticks = '0;
            delay_on    = 1'b0;
            clear_counts();
            predicted_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[strbr_pkg::AddrW-1:2] == strbr_pkg::RegHoldoff) begin
                    cfg_holdoff = pwdata[strbr_pkg::TickW-1:0];
                end else if (paddr[strbr_pkg::AddrW-1:2] == strbr_pkg::RegDelay) begin
                    cfg_delay = pwdata[strbr_pkg::TickW-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (predicted_reports.size() == 0) begin
                    $error("report arrived with no prediction waiting");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("byte_valid", want.byte_valid, i_out_data.byte_valid);
                    check_field("byte_value", want.byte_value, i_out_data.byte_value);
                    check_field("byte_position", want.byte_position,
                                i_out_data.byte_position);
                    check_field("message_end", want.message_end, i_out_data.message_end);
                    check_field("message_ready", want.message_ready,
                                i_out_data.message_ready);
                    check_field("blocks_received", want.blocks_received,
                                i_out_data.blocks_received);
                    check_field("edges_accepted", want.edges_accepted,
                                i_out_data.edges_accepted);
                    check_field("edges_rejected", want.edges_rejected,
                                i_out_data.edges_rejected);
                    check_field("bytes_sampled", want.bytes_sampled,
                                i_out_data.bytes_sampled);
                    check_field("busy_res", want.busy_res, i_out_data.busy_res);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_reports.push_back(predict_report(i_in_data));
            end
        end
        o_pending = predicted_reports.size();
    end

endmodule

// ----- sim/tb_strobed_parallel_byte_receiver.sv -----
// Testbench top for the strobed parallel byte receiver: stimulus, register writes and verdict.
module tb_strobed_parallel_byte_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [strbr_pkg::AddrW-1:0] HoldoffAddr = {strbr_pkg::RegHoldoff, 2'b00};
    localparam logic [strbr_pkg::AddrW-1:0] DelayAddr   = {strbr_pkg::RegDelay, 2'b00};
    localparam int NumPhases     = 8;
    localparam int ItemsPerPhase = 240;

    typedef enum logic [1:0] {StallNone, StallHalf, StallHeavy, StallPeriodic} t_stall_mode;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    strbr_pkg::t_in              in_data   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    strbr_pkg::t_out             out_data;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [strbr_pkg::AddrW-1:0] paddr     = '0;
    logic [strbr_pkg::DataW-1:0] pwdata    = '0;
    logic [strbr_pkg::DataW-1:0] reg_rdata;
    logic                        pready;
    int                          fail_count;
    int                          pending;

    int                          burst_left = 0;
    t_stall_mode                 stall_mode = StallNone;
    logic [7:0]                  stall_left = '0;

    always #10 clk = ~clk;

    strobed_parallel_byte_receiver DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (reg_rdata),
        .pready      (pready)
    );

    strbr_report_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The result side picks a new stall behavior whenever its countdown runs out.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= 8'($urandom_range(20, 200));
        end else begin
            stall_left <= stall_left - 1'b1;
        end
        case (stall_mode)
            StallNone:  out_stall <= 1'b0;
            StallHalf:  out_stall <= ($urandom_range(0, 1) == 1);
            StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
            default:    out_stall <= (stall_left[1:0] == 2'b00);
        endcase
    end

    function automatic strbr_pkg::t_in make_req(input logic kind, input logic strobe,
                                                 input logic [7:0] bus);
        strbr_pkg::t_in req;
        req.kind         = kind;
        req.strobe_level = strobe;
        req.bus_byte     = bus;
        return req;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input strbr_pkg::t_in req);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_tick(input logic strobe);
        logic kind;
        kind = ($urandom_range(0, 63) == 0) ? strbr_pkg::KindClear : strbr_pkg::KindTick;
        send_request(make_req(kind, strobe, 8'($urandom_range(0, 255))));
    endtask

    // Stop sending and wait until every predicted report has been checked.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [strbr_pkg::AddrW-1:0] addr,
                             input logic [strbr_pkg::DataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly clean strobe pulses, with stretches of random strobe levels.
    task automatic run_phase(input int n_items);
        int sent;
        int lo_len;
        int hi_len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) != 0) begin
                lo_len = $urandom_range(1, 8);
                hi_len = $urandom_range(1, 6);
                repeat (lo_len) begin
                    send_tick(1'b0);
                    sent++;
                end
                repeat (hi_len) begin
                    send_tick(1'b1);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    send_tick(1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [strbr_pkg::TickW-1:0] holdoff_val;
        logic [strbr_pkg::TickW-1:0] delay_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: edges right after reset fall inside the holdoff.
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h00));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'hFF));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h55));
        // Clear expires the holdoff, so the next edge is taken and starts a long delay.
        send_request(make_req(strbr_pkg::KindClear, 1'b1, 8'hAA));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'h00));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h0F));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'hF0));
        // A clear during the delay disarms the sample; the delay itself runs on.
        send_request(make_req(strbr_pkg::KindClear, 1'b0, 8'h00));
        drain();
        // Upper bits are dropped, so this is a delay of zero.
        write_reg(DelayAddr, 32'hFF00_0000);
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h3C));
        drain();
        write_reg(HoldoffAddr, 32'hAB00_0003);
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'h12));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h81));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'h7E));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h01));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'h80));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'hFF));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h00));
        drain();
        // With a delay of two, an edge on the tick the delay ends is dropped.
        write_reg(DelayAddr, 32'h0000_0002);
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h11));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'h22));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h33));
        send_request(make_req(strbr_pkg::KindTick, 1'b1, 8'h44));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h55));
        send_request(make_req(strbr_pkg::KindTick, 1'b0, 8'h66));
        drain();

        for (int phase = 0; phase < NumPhases; phase++) begin
            holdoff_val = strbr_pkg::TickW'($urandom_range(0, 10));
            delay_val   = strbr_pkg::TickW'($urandom_range(0, 6));
            if (phase == 0) begin
                holdoff_val = '0;
                delay_val   = strbr_pkg::TickW'(1);
            end else if (phase == 1) begin
                holdoff_val = strbr_pkg::TickMax;
            end else if (phase == 2) begin
                delay_val = strbr_pkg::TickMax;
            end
            write_reg(HoldoffAddr, {8'($urandom_range(0, 255)), holdoff_val});
            write_reg(DelayAddr, {8'($urandom_range(0, 255)), delay_val});
            if (phase == 1) begin
                send_request(make_req(strbr_pkg::KindClear, 1'b0,
                                      8'($urandom_range(0, 255))));
            end
            run_phase(ItemsPerPhase);
            drain();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/strbr_pkg.sv
rtl/strbr_core.sv
rtl/strobed_parallel_byte_receiver.sv
sim/strbr_report_checker.sv
sim/tb_strobed_parallel_byte_receiver.sv
